// ----- rtl/trb_pkg.sv -----
// Shared types, widths and codes of the trace ring buffer.
`default_nettype none

package trb_pkg;

	localparam int SLOTS  = 32;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(SLOTS + 1);

	localparam int STATE_W = 16;
	localparam int ID_W    = 22;
	localparam int NAME_W  = 64;
	localparam int COUNT_W = 32;
	localparam int COPY_W  = 6;

	localparam int IN_FIELDS_W  = STATE_W + 2 * ID_W + 2 * NAME_W + COUNT_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = STATE_W + 2 * ID_W + 2 * NAME_W + COUNT_W + COPY_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int ACT_W        = 2;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [CNT_W-1:0]  copy_cnt_t;

	localparam slot_t LAST_SLOT = slot_t'(SLOTS - 1);

	typedef enum logic [ACT_W-1:0] {
		ACT_RECORD = 2'd0,
		ACT_READ   = 2'd1,
		ACT_CLEAR  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		SC_IDLE,
		SC_EVAL,
		SC_SUMM
	} scan_state_t;

	// one slot as stored in the RAM, state in the lowest bits
	typedef struct packed {
		logic [NAME_W-1:0]  name_high;
		logic [NAME_W-1:0]  name_low;
		logic [ID_W-1:0]    group_id;
		logic [ID_W-1:0]    thread_id;
		logic [COUNT_W-1:0] count;
		logic [STATE_W-1:0] state;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		slot_t              wr_slot;
		logic [COUNT_W-1:0] total;
		logic [SLOTS-1:0]   valid;
		logic [SLOTS-1:0]   written;
	} slot_status_t;

endpackage

`default_nettype wire

// ----- rtl/trb_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none

module trb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/trb_slots.sv -----
// Record and clear handling: write slot, event count, valid and written bits.
`default_nettype none

module trb_slots (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           accept,
	input  wire logic [trb_pkg::ACT_W-1:0]      action,
	input  wire logic [trb_pkg::STATE_W-1:0]    event_state,
	input  wire logic [trb_pkg::ID_W-1:0]       group_id,
	input  wire logic [trb_pkg::ID_W-1:0]       thread_id,
	input  wire logic [trb_pkg::NAME_W-1:0]     name_low,
	input  wire logic [trb_pkg::NAME_W-1:0]     name_high,
	output logic                                we,
	output trb_pkg::slot_t                      waddr,
	output trb_pkg::entry_t                     wdata,
	output trb_pkg::slot_status_t               status
);

	import trb_pkg::*;

	slot_t              wr_slot_q;
	logic [COUNT_W-1:0] total_q;
	logic [SLOTS-1:0]   valid_q;
	logic [SLOTS-1:0]   written_q;
	logic               do_clear;

	assign we       = accept && (action == ACT_RECORD);
	assign do_clear = accept && (action == ACT_CLEAR);
	assign waddr    = wr_slot_q;

	always_comb begin
		wdata.name_high = name_high;
		wdata.name_low  = name_low;
		wdata.group_id  = group_id;
		wdata.thread_id = thread_id;
		wdata.count     = total_q;
		wdata.state     = event_state;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_slot_q <= '0;
			total_q   <= '0;
			valid_q   <= '0;
			written_q <= '0;
		end else if (we) begin
			valid_q[wr_slot_q]   <= 1'b1;
			written_q[wr_slot_q] <= 1'b1;
			wr_slot_q            <= (wr_slot_q == LAST_SLOT) ? '0 : wr_slot_q + 1'b1;
			// saturate at the top count
			if (total_q != '1) begin
				total_q <= total_q + 1'b1;
			end
		end else if (do_clear) begin
			valid_q <= '0;
		end
	end

	assign status.wr_slot = wr_slot_q;
	assign status.total   = total_q;
	assign status.valid   = valid_q;
	assign status.written = written_q;

endmodule

`default_nettype wire

// ----- rtl/trb_scan.sv -----
// Read walk over the slot RAM with window rules and the output beat register.
`default_nettype none

module trb_scan (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              accept,
	input  wire logic [trb_pkg::ACT_W-1:0]         action,
	input  wire logic [trb_pkg::COUNT_W-1:0]       start_count,
	input  wire trb_pkg::slot_status_t             status,
	input  wire trb_pkg::entry_t                   rdata,
	output logic                                   idle,
	output logic                                   re,
	output trb_pkg::slot_t                         raddr,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [trb_pkg::OUT_TDATA_W-1:0]        m_tdata,
	output logic                                   m_tuser,
	output logic                                   m_tlast
);

	import trb_pkg::*;

	scan_state_t        state_q, state_d;
	slot_t              idx_q, i_q, idx_next;
	logic [COUNT_W-1:0] start_q, total_q, nxt_q;
	copy_cnt_t          cnt_q;
	logic               out_valid_q, out_summ_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic [COUNT_W-1:0] c;
	logic               stop, below, copy, out_free;
	logic               begin_scan, adv, load_entry, load_summ;

	assign idx_next = (idx_q == LAST_SLOT) ? '0 : idx_q + 1'b1;
	assign out_free = !out_valid_q || m_tready;

	// a slot never written holds count zero
	assign c     = status.written[idx_q] ? rdata.count : '0;
	assign stop  = ((start_q != '0) &&
	                ({1'b0, c} > ({1'b0, start_q} + (COUNT_W+1)'(SLOTS)))) ||
	               ((total_q < COUNT_W'(SLOTS)) && (c >= total_q));
	assign below = (start_q != '0) && (c < start_q);
	assign copy  = !below && status.valid[idx_q];

	always_comb begin
		state_d    = state_q;
		re         = 1'b0;
		raddr      = idx_next;
		begin_scan = 1'b0;
		adv        = 1'b0;
		load_entry = 1'b0;
		load_summ  = 1'b0;
		case (state_q)
			SC_IDLE: begin
				raddr = status.wr_slot;
				if (accept && (action == ACT_READ)) begin
					re         = 1'b1;
					begin_scan = 1'b1;
					state_d    = SC_EVAL;
				end
			end
			SC_EVAL: begin
				if (stop) begin
					state_d = SC_SUMM;
				end else if (!copy || out_free) begin
					adv        = 1'b1;
					load_entry = copy;
					if (i_q == LAST_SLOT) begin
						state_d = SC_SUMM;
					end else begin
						re = 1'b1;
					end
				end
			end
			SC_SUMM: begin
				if (out_free) begin
					load_summ = 1'b1;
					state_d   = SC_IDLE;
				end
			end
			default: state_d = SC_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SC_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_entry || load_summ) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (begin_scan) begin
			idx_q   <= status.wr_slot;
			i_q     <= '0;
			start_q <= start_count;
			total_q <= status.total;
			nxt_q   <= start_count;
			cnt_q   <= '0;
		end else if (adv) begin
			idx_q <= idx_next;
			i_q   <= i_q + 1'b1;
			if (copy) begin
				nxt_q <= c;
				cnt_q <= cnt_q + 1'b1;
			end
		end
		if (load_entry) begin
			out_summ_q <= 1'b0;
			out_data_q <= {(OUT_TDATA_W-OUT_FIELDS_W)'(0), COPY_W'(0), COUNT_W'(0),
			               rdata.name_high, rdata.name_low, rdata.thread_id,
			               rdata.group_id, rdata.state};
		end else if (load_summ) begin
			out_summ_q <= 1'b1;
			out_data_q <= {(OUT_TDATA_W-OUT_FIELDS_W)'(0), COPY_W'(cnt_q), nxt_q,
			               (2*NAME_W + 2*ID_W + STATE_W)'(0)};
		end
	end

	assign idle     = (state_q == SC_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_summ_q;
	assign m_tlast  = out_summ_q;

endmodule

`default_nettype wire

// ----- rtl/trace_ring_buffer_top.sv -----
// Trace ring buffer: record and clear complete as they are taken; a read beat is taken only when
// idle and walks the slot RAM one slot per cycle, set by its single read port, while the output
// does not stall, and s_tready stays low until the summary beat is loaded.
// Entry beats then the summary beat leave through one output register.
// Reset clears valid and written bits, write slot and event count; RAM contents are not reset,
// and a slot not yet written reads as count zero.
`default_nettype none

module trace_ring_buffer_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// event_state, group_id, thread_id, name_low, name_high, start_count
	input  wire logic [trb_pkg::IN_TDATA_W-1:0]   s_tdata,
	// action
	input  wire logic [trb_pkg::ACT_W-1:0]        s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// entry_state, entry_group_id, entry_thread_id, entry_name_low, entry_name_high,
	// next_counter, copied_count
	output logic [trb_pkg::OUT_TDATA_W-1:0]       m_tdata,
	// is_summary
	output logic                                  m_tuser,
	output logic                                  m_tlast
);

	import trb_pkg::*;

	localparam int O_GRP   = STATE_W;
	localparam int O_THR   = O_GRP + ID_W;
	localparam int O_NLO   = O_THR + ID_W;
	localparam int O_NHI   = O_NLO + NAME_W;
	localparam int O_START = O_NHI + NAME_W;

	logic         accept, idle, we, re;
	slot_t        waddr, raddr;
	entry_t       wdata, rdata;
	slot_status_t status;
	logic [ENTRY_W-1:0] rdata_raw;

	assign s_tready = idle;
	assign accept   = s_tvalid && s_tready;
	assign rdata    = entry_t'(rdata_raw);

	trb_slots u_slots (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.action      (s_tuser),
		.event_state (s_tdata[STATE_W-1:0]),
		.group_id    (s_tdata[O_GRP +: ID_W]),
		.thread_id   (s_tdata[O_THR +: ID_W]),
		.name_low    (s_tdata[O_NLO +: NAME_W]),
		.name_high   (s_tdata[O_NHI +: NAME_W]),
		.we          (we),
		.waddr       (waddr),
		.wdata       (wdata),
		.status      (status)
	);

	trb_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata_raw)
	);

	trb_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.action      (s_tuser),
		.start_count (s_tdata[O_START +: COUNT_W]),
		.status      (status),
		.rdata       (rdata),
		.idle        (idle),
		.re          (re),
		.raddr       (raddr),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

endmodule

`default_nettype wire

// ----- rtl/trb_checker.sv -----
// Port-level checks of the trace ring buffer, bound to the top level.
`default_nettype none

module trb_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_tvalid,
	input wire logic                             s_tready,
	input wire logic [trb_pkg::ACT_W-1:0]        s_tuser,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready,
	input wire logic [trb_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input wire logic                             m_tuser,
	input wire logic                             m_tlast
);

	import trb_pkg::*;

	localparam int O_COPY = OUT_FIELDS_W - COPY_W;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat changed while stalled");

	// a read locks out the input while the walk runs
	a_read_lock: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == ACT_READ) |=> !s_tready)
		else $error("input taken during a read walk");

	// only the summary closes a read
	a_last_summ: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == m_tuser))
		else $error("last flag and summary flag disagree");

	// copy count fits the buffer and is zero on entry beats
	a_copy_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser ? (m_tdata[O_COPY +: COPY_W] <= COPY_W'(SLOTS))
		                      : (m_tdata[O_COPY +: COPY_W] == '0)))
		else $error("copied count out of range");

endmodule

bind trace_ring_buffer_top trb_checker u_trb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire
